### hw/rtl/erm_pkg.sv
`timescale 1ns / 1ps

package erm_pkg;

  // fixed field widths
  localparam int TIME_IN_W = 48;
  localparam int RATE_W    = 40;
  localparam int PCT_W     = 7;

  // parameter defaults
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_TIME_WIDTH  = 48;
  localparam int DEF_FRAC_BITS   = 8;

  // microseconds per second, fed to the multiplier one bit per cycle
  localparam int MPLR_W = 20;
  localparam logic [MPLR_W-1:0] US_PER_S = MPLR_W'(1000000);

  localparam int PCT_DIV = 100;
  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(3);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_RMUL_GO,
    S_RMUL,
    S_RDIV_GO,
    S_RDIV,
    S_CHECK,
    S_TMUL_GO,
    S_TMUL,
    S_TDIV_GO,
    S_TDIV
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### hw/rtl/erm_if.sv
`timescale 1ns / 1ps

interface event_in_if;
  import erm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TIME_IN_W-1:0] event_time_us;

  modport source (output valid, output event_time_us, input ready);
  modport sink (input valid, input event_time_us, output ready);
endinterface

interface result_out_if;
  import erm_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_q8;
  logic              rate_valid;
  logic              significant_change;

  modport source (output valid, output rate_q8, output rate_valid,
                  output significant_change, input ready);
  modport sink (input valid, input rate_q8, input rate_valid,
                input significant_change, output ready);
endinterface

### hw/rtl/erm_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier: one multiplier bit per cycle, stops once the
// remaining multiplier bits are all zero.
module erm_mul #(
  parameter int A_W = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [A_W-1:0]                      a,
  input  logic [erm_pkg::MPLR_W-1:0]          b,
  output logic [A_W+erm_pkg::MPLR_W-1:0]      product,
  output erm_pkg::unit_stat_t                 stat
);
  import erm_pkg::*;

  localparam int P_W = A_W + MPLR_W;

  logic             busy;
  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   mc;
  logic [MPLR_W-1:0] mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mp == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mc  <= P_W'(a);
      mp  <= b;
    end else if (busy && mp != '0) begin
      acc <= acc + (mp[0] ? mc : '0);
      mc  <= mc << 1;
      mp  <= mp >> 1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = busy && (mp == '0);

endmodule

### hw/rtl/erm_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is RATE_W bits;
// when the dividend bits above the quotient already reach the divisor the
// quotient cannot fit and the result saturates (this covers a zero divisor).
module erm_div #(
  parameter int N_W = 84,
  parameter int D_W = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [N_W-1:0]              dividend,
  input  logic [D_W-1:0]              divisor,
  output logic [erm_pkg::RATE_W-1:0]  quotient,
  output erm_pkg::unit_stat_t         stat
);
  import erm_pkg::*;

  localparam int TOP_W = N_W - RATE_W;
  localparam int CMP_W = imax(TOP_W, D_W);
  localparam int CNT_W = $clog2(RATE_W + 1);

  logic              busy;
  logic              sat;
  logic [CNT_W-1:0]  cnt;
  logic [D_W-1:0]    dvs;
  logic [D_W-1:0]    rem;
  logic [RATE_W-1:0] qsh;
  logic [D_W:0]      rem2;
  logic [D_W:0]      rem_sub;
  logic              ge;
  logic              top_ge;

  assign top_ge  = CMP_W'(dividend[N_W-1:RATE_W]) >= CMP_W'(divisor);
  assign rem2    = {rem, qsh[RATE_W-1]};
  assign ge      = rem2 >= {1'b0, dvs};
  assign rem_sub = rem2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // qsh starts as the low dividend bits and fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      sat <= top_ge;
      cnt <= CNT_W'(RATE_W);
      dvs <= divisor;
      rem <= D_W'(dividend[N_W-1:RATE_W]);
      qsh <= dividend[RATE_W-1:0];
    end else if (busy && cnt != '0) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? rem_sub[D_W-1:0] : rem2[D_W-1:0];
      qsh <= {qsh[RATE_W-2:0], ge};
    end
  end

  assign quotient  = sat ? '1 : qsh;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == '0);

endmodule

### hw/rtl/event_rate_meter.sv
`timescale 1ns / 1ps

// Channel | Dir | Beat payload
// --------+-----+----------------------------------------------------
// evt     | in  | event_time_us
// res     | out | rate_q8, rate_valid, significant_change
//
// Events after the first run a 20-step shift-add multiply by 1e6 and a
// 40-step restoring divide. When a significant change refreshes the
// threshold, a second multiply (percent) and divide (by 100) run before
// the next event is taken. rst is synchronous; it clears the count, start
// time, accepted rate and threshold and sets percent to 3. A stalled res
// holds its beat; the block keeps working and waits only when a new result
// meets a full output.
module event_rate_meter #(
  parameter int COUNT_WIDTH = erm_pkg::DEF_COUNT_WIDTH,
  parameter int TIME_WIDTH  = erm_pkg::DEF_TIME_WIDTH,
  parameter int FRAC_BITS   = erm_pkg::DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [erm_pkg::PCT_W-1:0] cfg_wr_data,
  event_in_if.sink                 evt,
  result_out_if.source             res
);
  import erm_pkg::*;

  localparam int MC_W  = imax(COUNT_WIDTH, RATE_W);
  localparam int P_W   = MC_W + MPLR_W;
  localparam int DIV_N = imax(COUNT_WIDTH + MPLR_W + FRAC_BITS, RATE_W + PCT_W);

  state_t state, state_next;

  logic [COUNT_WIDTH-1:0] count;
  logic [TIME_WIDTH-1:0]  start_time;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [TIME_WIDTH-1:0]  now;
  logic [RATE_W-1:0]      accepted_rate;
  logic [RATE_W-1:0]      change_threshold;
  logic [PCT_W-1:0]       percent;

  logic              ovalid;
  logic [RATE_W-1:0] orate;
  logic              orv;
  logic              osig;

  logic in_ready, mul_start, div_start, sel_thr, load_out, out_free;
  logic accept;

  logic [MC_W-1:0]   mul_a;
  logic [MPLR_W-1:0] mul_b;
  logic [P_W-1:0]    product;
  unit_stat_t        mul_stat;

  logic [DIV_N-1:0]      div_n;
  logic [TIME_WIDTH-1:0] div_d;
  logic [RATE_W-1:0]     quotient;
  unit_stat_t            div_stat;

  logic [RATE_W-1:0] diff;
  logic              sig;

  assign now      = TIME_WIDTH'(evt.event_time_us);
  assign accept   = evt.valid && in_ready;
  assign out_free = !ovalid || res.ready;

  assign evt.ready              = in_ready;
  assign res.valid              = ovalid;
  assign res.rate_q8            = orate;
  assign res.rate_valid         = orv;
  assign res.significant_change = osig;

  // operand select for the shared units
  assign mul_a = sel_thr ? MC_W'(accepted_rate) : MC_W'(count);
  assign mul_b = sel_thr ? MPLR_W'(percent) : US_PER_S;
  assign div_n = sel_thr ? DIV_N'(product) : (DIV_N'(product) << FRAC_BITS);
  assign div_d = sel_thr ? TIME_WIDTH'(PCT_DIV) : elapsed;

  erm_mul #(.A_W(MC_W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (product),
    .stat    (mul_stat)
  );

  erm_div #(.N_W(DIV_N), .D_W(TIME_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    diff = (accepted_rate > quotient) ? accepted_rate - quotient
                                      : quotient - accepted_rate;
    sig  = diff > change_threshold;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = (count == '0) ? S_FIRST : S_RMUL_GO;
      end
      S_FIRST: begin
        if (out_free) state_next = S_IDLE;
      end
      S_RMUL_GO: state_next = S_RMUL;
      S_RMUL: begin
        if (mul_stat.done) state_next = S_RDIV_GO;
      end
      S_RDIV_GO: state_next = S_RDIV;
      S_RDIV: begin
        if (div_stat.done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (out_free) state_next = sig ? S_TMUL_GO : S_IDLE;
      end
      S_TMUL_GO: state_next = S_TMUL;
      S_TMUL: begin
        if (mul_stat.done) state_next = S_TDIV_GO;
      end
      S_TDIV_GO: state_next = S_TDIV;
      S_TDIV: begin
        if (div_stat.done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    sel_thr   = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE:           in_ready = 1'b1;
      S_FIRST, S_CHECK: load_out = out_free;
      S_RMUL_GO:        mul_start = 1'b1;
      S_RDIV_GO:        div_start = 1'b1;
      S_TMUL_GO: begin
        mul_start = 1'b1;
        sel_thr   = 1'b1;
      end
      S_TDIV_GO: begin
        div_start = 1'b1;
        sel_thr   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      start_time       <= '0;
      accepted_rate    <= '0;
      change_threshold <= '0;
      percent          <= PCT_RESET;
      ovalid           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) percent <= cfg_wr_data;
      if (accept) begin
        if (count != '1) count <= count + 1'b1;
        if (count == '0) start_time <= now;
      end
      if (state == S_CHECK && out_free && sig) accepted_rate <= quotient;
      if (state == S_TDIV && div_stat.done) change_threshold <= quotient;
      // drop the beat once taken, hold it otherwise
      if (load_out) ovalid <= 1'b1;
      else if (res.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) elapsed <= now - start_time;
    if (load_out) begin
      if (state == S_FIRST) begin
        orate <= '0;
        orv   <= 1'b0;
        osig  <= 1'b0;
      end else begin
        orate <= quotient;
        orv   <= 1'b1;
        osig  <= sig;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_RMUL || state == S_TMUL))
    else $error("multiplier finished outside a multiply wait");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_RDIV || state == S_TDIV))
    else $error("divider finished outside a divide wait");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!ovalid || res.ready))
    else $error("result loaded over a pending beat");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count >= $past(count))
    else $error("event count went down");

  a_sig_has_rate: assert property (@(posedge clk) disable iff (rst)
    (ovalid && osig) |-> orv)
    else $error("change flagged without a rate");
`endif

endmodule
